### hw/rtl/lgc_pkg.sv
// ----------------------------------------------------------------------------
// lgc_pkg
// Shared types and constants of the glyph cache tag unit: slot count,
// field widths, transaction structs and the controller-to-datapath command.
// ----------------------------------------------------------------------------
`default_nettype none

package lgc_pkg;

   localparam int SLOTS       = 8;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TREE_LEVELS = SLOT_W;
   localparam int TREE_SIZE   = 1 << SLOT_W;
   localparam int TAG_W       = 16;
   localparam int AGE_W       = 32;
   localparam int SLOT_OUT_W  = 3;

   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   typedef struct packed {
      logic             op;
      logic [TAG_W-1:0] glyph_id;
      logic             fill_ok;
   } req_type;

   typedef struct packed {
      logic                  ok;
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic lookup;
      logic commit;
   } cmd_type;

endpackage

`default_nettype wire

### hw/rtl/lru_glyph_cache_tags_unit.sv
// ----------------------------------------------------------------------------
// lru_glyph_cache_tags_unit
// Tag and LRU replacement controller of a fully associative glyph cache.
// ----------------------------------------------------------------------------
// Each transaction passes from acceptance through a lookup cycle (parallel
// tag compare across all slots and a registered-out age minimum tree) and a
// commit cycle that writes tags, valid bits, ages and the use counter and
// loads the response register. The next request is taken in the commit cycle,
// so a new request overlaps the last one only there and never its lookup;
// a stalled response holds the commit and with it the input. A flush clears
// all slots and the counter in its commit cycle. No clearing pass follows
// reset.
`default_nettype none

module lru_glyph_cache_tags_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lgc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lgc_pkg::rsp_type      rsp_data
);
   import lgc_pkg::*;

   cmd_type cmd;

   lgc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   lgc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

### hw/rtl/lgc_ctrl.sv
// ----------------------------------------------------------------------------
// lgc_ctrl
// Sequencer of the tag unit: takes a request, runs the lookup cycle, then
// commits the update and loads the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module lgc_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lgc_pkg::cmd_type      cmd
);
   import lgc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;
   logic      commit;
   logic      take_req;
   logic      load_req;

   always_comb begin
      rsp_free = !rsp_valid_ff || !rsp_stall;
      commit   = (state_ff == ST_UPDATE) && rsp_free;
      // a new request may enter in the same cycle the previous one commits
      take_req = (state_ff == ST_IDLE) || commit;
      load_req = req_valid && take_req;

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (load_req) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (commit) state_in = load_req ? ST_LOOKUP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall    = !take_req;
   assign rsp_valid    = rsp_valid_ff;
   assign cmd.load_req = load_req;
   assign cmd.lookup   = (state_ff == ST_LOOKUP);
   assign cmd.commit   = commit;

endmodule

`default_nettype wire

### hw/rtl/lgc_datapath.sv
// ----------------------------------------------------------------------------
// lgc_datapath
// Slot tags, valid bits, ages and use counter. Lookup cycle registers the
// hit slot and the victim; commit cycle updates the slots and the response.
// ----------------------------------------------------------------------------
`default_nettype none

module lgc_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lgc_pkg::cmd_type cmd,
   input  wire lgc_pkg::req_type req_data,
   output lgc_pkg::rsp_type      rsp_data
);
   import lgc_pkg::*;

   req_type           req_ff;
   rsp_type           rsp_ff, rsp_in;

   logic [SLOTS-1:0]  slot_valid_ff;
   logic [TAG_W-1:0]  slot_tag_ff [SLOTS];
   logic [AGE_W-1:0]  slot_age_ff [SLOTS];
   logic [AGE_W-1:0]  use_counter_ff;

   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] hit_idx_ff, hit_idx_in;
   logic [SLOT_W-1:0] victim_ff, victim_in;

   logic [AGE_W-1:0]  lvl_age [TREE_LEVELS+1][TREE_SIZE];
   logic [SLOT_W-1:0] lvl_idx [TREE_LEVELS+1][TREE_SIZE];

   logic [SLOT_W-1:0] commit_idx;
   logic              commit_ok;
   logic [AGE_W-1:0]  next_count;

   // parallel tag compare, lowest matching slot wins
   always_comb begin
      hit_in     = 1'b0;
      hit_idx_in = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (slot_valid_ff[i] && (slot_tag_ff[i] == req_ff.glyph_id)) begin
            hit_in     = 1'b1;
            hit_idx_in = SLOT_W'(i);
         end
      end
   end

   // age minimum tree; padding leaves hold the largest age and a higher index
   always_comb begin
      for (int l = 0; l <= TREE_LEVELS; l++) begin
         for (int j = 0; j < TREE_SIZE; j++) begin
            lvl_age[l][j] = '1;
            lvl_idx[l][j] = SLOT_W'(j);
         end
      end
      for (int j = 0; j < SLOTS; j++) begin
         lvl_age[0][j] = slot_age_ff[j];
      end
      for (int l = 0; l < TREE_LEVELS; l++) begin
         for (int j = 0; j < (TREE_SIZE >> (l + 1)); j++) begin
            // strict compare keeps the lower index on a tie
            if (lvl_age[l][2*j+1] < lvl_age[l][2*j]) begin
               lvl_age[l+1][j] = lvl_age[l][2*j+1];
               lvl_idx[l+1][j] = lvl_idx[l][2*j+1];
            end else begin
               lvl_age[l+1][j] = lvl_age[l][2*j];
               lvl_idx[l+1][j] = lvl_idx[l][2*j];
            end
         end
      end
   end

   // victim: first free slot from 1 up, then slot 0, then the oldest
   always_comb begin
      victim_in = lvl_idx[TREE_LEVELS][0];
      if (!slot_valid_ff[0]) victim_in = '0;
      for (int i = SLOTS - 1; i >= 1; i--) begin
         if (!slot_valid_ff[i]) victim_in = SLOT_W'(i);
      end
   end

   always_comb begin
      commit_idx = hit_ff ? hit_idx_ff : victim_ff;
      commit_ok  = hit_ff || req_ff.fill_ok;
      next_count = use_counter_ff + AGE_W'(1);
      if (req_ff.op == OP_FLUSH) begin
         rsp_in.ok   = 1'b1;
         rsp_in.hit  = 1'b0;
         rsp_in.slot = '0;
      end else begin
         rsp_in.ok   = commit_ok;
         rsp_in.hit  = hit_ff;
         rsp_in.slot = SLOT_OUT_W'(commit_idx);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_data;
      if (cmd.lookup) begin
         hit_ff     <= hit_in;
         hit_idx_ff <= hit_idx_in;
         victim_ff  <= victim_in;
      end
      if (cmd.commit) rsp_ff <= rsp_in;
      if (cmd.commit && (req_ff.op == OP_ACCESS) && !hit_ff && req_ff.fill_ok) begin
         slot_tag_ff[commit_idx] <= req_ff.glyph_id;
      end
   end

   // slot state
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff  <= '0;
         use_counter_ff <= '0;
         for (int i = 0; i < SLOTS; i++) slot_age_ff[i] <= '0;
      end else if (cmd.commit) begin
         if (req_ff.op == OP_FLUSH) begin
            slot_valid_ff  <= '0;
            use_counter_ff <= '0;
            for (int i = 0; i < SLOTS; i++) slot_age_ff[i] <= '0;
         end else begin
            if (!hit_ff) slot_valid_ff[commit_idx] <= req_ff.fill_ok;
            if (commit_ok) begin
               use_counter_ff          <= next_count;
               slot_age_ff[commit_idx] <= next_count;
            end
         end
      end
   end

   assign rsp_data = rsp_ff;

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (req_ff.op == OP_FLUSH))
      |=> (use_counter_ff == '0) && (slot_valid_ff == '0))
      else $error("flush left live slots or a nonzero use counter");

   a_served_slot_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (req_ff.op == OP_ACCESS) && commit_ok)
      |=> slot_valid_ff[$past(commit_idx)]
          && (slot_age_ff[$past(commit_idx)] == use_counter_ff))
      else $error("served slot not valid or not stamped with the counter");

   a_hit_matches: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (req_ff.op == OP_ACCESS) && hit_ff)
      |-> slot_valid_ff[hit_idx_ff] && (slot_tag_ff[hit_idx_ff] == req_ff.glyph_id))
      else $error("hit reported on a slot that does not hold the glyph");

endmodule

`default_nettype wire

### tb/sv/lgc_tags_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgc_tags_checker
// Watches both channels of the glyph cache tag unit. Every accepted request
// goes through a local copy of the slot state to give the expected response.
// Each accepted response is compared field by field with the oldest one.
// ----------------------------------------------------------------------------

module lgc_tags_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  lgc_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  lgc_pkg::rsp_type rsp_data,
   output int               mismatches,
   output int               outstanding,
   output int               responses_checked,
   output int               hit_count,
   output int               failed_fill_count
);
   import lgc_pkg::*;

   logic             slot_live  [SLOTS];
   logic [TAG_W-1:0] slot_glyph [SLOTS];
   logic [AGE_W-1:0] slot_stamp [SLOTS];
   logic [AGE_W-1:0] stamp_counter;

   rsp_type expected_rsp_q [$];
   int      mismatch_total;
   int      checked_total;
   int      hit_total;
   int      fail_total;

   // first free slot above 0, then slot 0, then the oldest stamp (lowest index on a tie)
   function automatic int pick_victim();
      int               best;
      int               free_slot;
      logic [AGE_W-1:0] oldest;
      best      = 0;
      free_slot = -1;
      oldest    = slot_stamp[0];
      for (int i = 1; i < SLOTS; i++) begin
         if (free_slot < 0) begin
            if (!slot_live[i]) begin
               free_slot = i;
            end else if (slot_stamp[i] < oldest) begin
               oldest = slot_stamp[i];
               best   = i;
            end
         end
      end
      if (free_slot >= 0) return free_slot;
      if (!slot_live[0]) return 0;
      return best;
   endfunction

   function automatic rsp_type serve_request(req_type r);
      rsp_type res;
      int      idx;
      logic    served;
      res = '0;
      if (r.op == OP_FLUSH) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_live[i]  = 1'b0;
            slot_stamp[i] = '0;
         end
         stamp_counter = '0;
         res.ok        = 1'b1;
         return res;
      end
      idx = -1;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (slot_live[i] && slot_glyph[i] == r.glyph_id) idx = i;
      end
      served = 1'b1;
      if (idx >= 0) begin
         res.hit = 1'b1;
      end else begin
         idx = pick_victim();
         if (r.fill_ok) begin
            slot_glyph[idx] = r.glyph_id;
            slot_live[idx]  = 1'b1;
         end else begin
            slot_live[idx] = 1'b0;
            served         = 1'b0;
         end
      end
      if (served) begin
         stamp_counter   = stamp_counter + 1'b1;
         slot_stamp[idx] = stamp_counter;
      end
      res.ok   = served;
      res.slot = idx[SLOT_OUT_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_live[i]  = 1'b0;
            slot_glyph[i] = '0;
            slot_stamp[i] = '0;
         end
         stamp_counter = '0;
         expected_rsp_q.delete();
         mismatch_total = 0;
         checked_total  = 0;
         hit_total      = 0;
         fail_total     = 0;
      end else begin
         if (req_valid && !req_stall) begin
            want = serve_request(req_data);
            expected_rsp_q.push_back(want);
            if (want.hit) hit_total++;
            if (!want.ok) fail_total++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("[%0t] response with no transaction pending: %s%0b %s%0b %s%0d",
                           $realtime, "ok=", rsp_data.ok, "hit=", rsp_data.hit,
                           "slot=", rsp_data.slot);
            end else begin
               want = expected_rsp_q.pop_front();
               checked_total++;
               if (rsp_data.ok !== want.ok || rsp_data.hit !== want.hit ||
                   rsp_data.slot !== want.slot) begin
                  mismatch_total++;
                  if (mismatch_total <= 10)
                     $display({"[%0t] response %0d: expected ok=%0b hit=%0b slot=%0d, ",
                               "got ok=%0b hit=%0b slot=%0d"},
                              $realtime, checked_total, want.ok, want.hit, want.slot,
                              rsp_data.ok, rsp_data.hit, rsp_data.slot);
               end
            end
         end
      end
      mismatches        <= mismatch_total;
      outstanding       <= expected_rsp_q.size();
      responses_checked <= checked_total;
      hit_count         <= hit_total;
      failed_fill_count <= fail_total;
   end

endmodule

### tb/sv/tb_lru_glyph_cache_tags_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_glyph_cache_tags_unit
// Drives access and flush transactions into the glyph cache tag unit with
// random gaps and response stalls; a checker beside the block predicts and
// compares every response, and this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_lru_glyph_cache_tags_unit;
   import lgc_pkg::*;

   localparam int ITEM_TARGET   = 1820;
   localparam int HOLD_CYCLES   = 250;
   localparam int STUCK_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic    want_hold = 1'b0;
   int      mismatches;
   int      outstanding;
   int      responses_checked;
   int      hit_count;
   int      failed_fill_count;
   int      items_sent   = 0;
   int      flushes_sent = 0;
   int      drain_pauses = 0;
   int      holds_done   = 0;
   int      stuck_cycles = 0;

   always #1 clock = ~clock;

   lru_glyph_cache_tags_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   lgc_tags_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data),
      .mismatches        (mismatches),
      .outstanding       (outstanding),
      .responses_checked (responses_checked),
      .hit_count         (hit_count),
      .failed_fill_count (failed_fill_count)
   );

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("no transaction for %0d cycles", STUCK_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // response side: random stall runs, free stretches, and a long hold on request
   initial begin
      logic hold_seen;
      logic level;
      int   run;
      int   pick;
      hold_seen = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (want_hold && !hold_seen) begin
            hold_seen = 1'b1;
            level     = 1'b1;
            run       = HOLD_CYCLES;
            holds_done++;
         end else begin
            if (!want_hold) hold_seen = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               level = 1'b0;
               run   = $urandom_range(1, 6);
            end else if (pick < 60) begin
               level = 1'b0;
               run   = $urandom_range(30, 80);
            end else if (pick < 93) begin
               level = 1'b1;
               run   = $urandom_range(1, 3);
            end else begin
               level = 1'b1;
               run   = $urandom_range(10, 40);
            end
         end
         rsp_stall <= level;
         repeat (run) @(posedge clock);
      end
   end

   function automatic req_type make_req(logic op, logic [TAG_W-1:0] id, logic fill);
      req_type r;
      r.op       = op;
      r.glyph_id = id;
      r.fill_ok  = fill;
      return r;
   endfunction

   function automatic int pick_gap(logic bursty);
      int pick;
      if (!bursty) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // holds valid until the transaction is taken; returns at the accepting edge
   task automatic offer_req(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (item.op == OP_FLUSH) flushes_sent++;
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      req_type          directed_q [$];
      logic [TAG_W-1:0] pool [16];
      int               pool_size;
      int               batch;
      int               batch_len;
      int               pick;
      int               hold_base;
      logic             bursty;
      logic [TAG_W-1:0] id;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // fill an empty cache, hit, fail a fill, then age slot 0 out so a failed
      // fill frees it and the next miss has to take it back
      directed_q.push_back(make_req(OP_FLUSH, 16'hA5C3, 1'b0));
      directed_q.push_back(make_req(OP_ACCESS, 16'h0000, 1'b1));
      directed_q.push_back(make_req(OP_ACCESS, 16'hFFFF, 1'b1));
      directed_q.push_back(make_req(OP_ACCESS, 16'h0000, 1'b0));
      directed_q.push_back(make_req(OP_ACCESS, 16'h8001, 1'b0));
      for (int i = 1; i <= 6; i++)
         directed_q.push_back(make_req(OP_ACCESS, TAG_W'(i), 1'b1));
      directed_q.push_back(make_req(OP_ACCESS, 16'h0000, 1'b1));
      directed_q.push_back(make_req(OP_ACCESS, 16'hFFFF, 1'b1));
      for (int i = 1; i <= 5; i++)
         directed_q.push_back(make_req(OP_ACCESS, TAG_W'(i), 1'b1));
      directed_q.push_back(make_req(OP_ACCESS, 16'h7FFE, 1'b0));
      directed_q.push_back(make_req(OP_ACCESS, 16'h7FFE, 1'b1));
      directed_q.push_back(make_req(OP_ACCESS, 16'h5555, 1'b1));
      directed_q.push_back(make_req(OP_FLUSH, 16'hFFFF, 1'b1));
      directed_q.push_back(make_req(OP_ACCESS, 16'hFFFF, 1'b1));
      foreach (directed_q[k]) begin
         offer_req(directed_q[k]);
         idle_sender(pick_gap(1'b1));
      end

      batch = 0;
      while (items_sent < ITEM_TARGET) begin
         batch++;
         pool_size = $urandom_range(3, 14);
         for (int i = 0; i < 16; i++) pool[i] = TAG_W'($urandom);
         bursty    = ($urandom_range(0, 3) != 0);
         batch_len = $urandom_range(40, 120);

         if (batch == 4) begin
            // receiver holds off while the sender keeps pushing; keep asking
            // until the response side has actually started the hold
            hold_base = holds_done;
            want_hold <= 1'b1;
            for (int i = 0; (i < 16) || (holds_done == hold_base); i++)
               offer_req(make_req(OP_ACCESS, pool[i % pool_size], 1'b1));
            want_hold <= 1'b0;
         end

         for (int j = 0; j < batch_len; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
               offer_req(make_req(OP_FLUSH, TAG_W'($urandom), 1'($urandom)));
            end else begin
               if (pick < 7) id = TAG_W'($urandom);
               else id = pool[$urandom_range(0, pool_size - 1)];
               offer_req(make_req(OP_ACCESS, id, $urandom_range(0, 99) < 85));
            end
            idle_sender(pick_gap(bursty));
         end

         if (batch % 6 == 5) begin
            // sender quiet until every response is back
            req_valid <= 1'b0;
            wait_drained();
            drain_pauses++;
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d transactions (%0d flushes); %0d responses checked",
               items_sent, flushes_sent, responses_checked);
      $display("%0d hits, %0d failed fills, %0d long receiver hold-offs, %0d drains, %0d mismatches",
               hit_count, failed_fill_count, holds_done, drain_pauses, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
